/* rtl/tqrc_pkg.sv */
// Shared types, widths and helpers for the textured quad rectangle clipper.
package tqrc_pkg;

    localparam int POS_WIDTH     = 16;
    localparam int UV_WIDTH      = 16;
    localparam int EW            = POS_WIDTH + 1;
    localparam int DW            = POS_WIDTH + 2;
    localparam int DU            = DW - 1;
    localparam int NW            = UV_WIDTH + DU;
    localparam int NUM_LANES     = 4;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_OFFSET_X,
        CFG_OFFSET_Z,
        CFG_CLIP_LEFT,
        CFG_CLIP_BOTTOM,
        CFG_CLIP_RIGHT,
        CFG_CLIP_TOP
    } t_cfg_idx;

    typedef logic        [UV_WIDTH-1:0]  t_uv;
    typedef logic signed [POS_WIDTH-1:0] t_pos;
    typedef logic signed [EW-1:0]        t_edge;
    typedef logic signed [DW-1:0]        t_diff;

    typedef struct packed {
        t_pos left_x;
        t_pos bottom_z;
        t_pos right_x;
        t_pos top_z;
        t_uv  tex_u0;
        t_uv  tex_v0;
        t_uv  tex_u1;
        t_uv  tex_v1;
        t_uv  tex_u2;
        t_uv  tex_v2;
        t_uv  tex_u3;
        t_uv  tex_v3;
    } t_in;

    typedef struct packed {
        t_pos out_left_x;
        t_pos out_bottom_z;
        t_pos out_right_x;
        t_pos out_top_z;
        t_uv  out_u0;
        t_uv  out_v0;
        t_uv  out_u1;
        t_uv  out_v1;
        t_uv  out_u2;
        t_uv  out_v2;
        t_uv  out_u3;
        t_uv  out_v3;
    } t_out;

    typedef struct packed {
        t_pos offset_x;
        t_pos offset_z;
        t_pos clip_left;
        t_pos clip_bottom;
        t_pos clip_right;
        t_pos clip_top;
    } t_cfg;

    typedef struct packed {
        t_edge      l;
        t_edge      b;
        t_edge      r;
        t_edge      t;
        t_uv [3:0]  u;
        t_uv [3:0]  v;
    } t_quad;

    typedef struct packed {
        logic  en;
        t_uv   a;
        t_uv   f;
        t_diff n;
        t_diff d;
    } t_lane;

    typedef struct packed {
        logic          pa;
        logic          pf;
        t_uv           a;
        t_uv           f;
        logic [DU-1:0] d;
        logic [NW-1:0] p1;
        logic [NW-1:0] p2;
    } t_mlane;

    typedef struct packed {
        logic          pa;
        logic          pf;
        t_uv           a;
        t_uv           f;
        logic [DU-1:0] d;
        logic [NW-1:0] rem;
        t_uv           q;
    } t_dlane;

    function automatic t_edge ext_e(input t_pos x);
        return {x[POS_WIDTH-1], x};
    endfunction

    function automatic t_diff ext_d(input t_edge x);
        return {x[EW-1], x};
    endfunction

    function automatic t_pos sat_pos(input t_edge x);
        if (x[EW-1] != x[EW-2]) begin
            return {x[EW-1], {(POS_WIDTH-1){~x[EW-1]}}};
        end
        return x[POS_WIDTH-1:0];
    endfunction

endpackage

/* rtl/tqrc_xlate.sv */
// Input stage: adds the string offset to the quad edges.
module tqrc_xlate import tqrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_data,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    input  logic  i_ready,
    output t_quad o_item
);

    logic  r_valid;
    t_quad r_item;
    t_quad n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.l    = ext_e(i_data.left_x) + ext_e(i_cfg.offset_x);
        n_item.b    = ext_e(i_data.bottom_z) + ext_e(i_cfg.offset_z);
        n_item.r    = ext_e(i_data.right_x) + ext_e(i_cfg.offset_x);
        n_item.t    = ext_e(i_data.top_z) + ext_e(i_cfg.offset_z);
        n_item.u[0] = i_data.tex_u0;
        n_item.v[0] = i_data.tex_v0;
        n_item.u[1] = i_data.tex_u1;
        n_item.v[1] = i_data.tex_v1;
        n_item.u[2] = i_data.tex_u2;
        n_item.v[2] = i_data.tex_v2;
        n_item.u[3] = i_data.tex_u3;
        n_item.v[3] = i_data.tex_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/tqrc_setup.sv */
// Clamp setup stage: cull test (first pass), edge clamps and lane operands.
module tqrc_setup import tqrc_pkg::*; #(
    parameter int PHASE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_quad                 i_item,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_quad                 o_item,
    output t_lane [NUM_LANES-1:0] o_lane
);

    logic                  r_valid;
    t_quad                 r_item;
    t_lane [NUM_LANES-1:0] r_lane;
    t_quad                 n_item;
    t_lane [NUM_LANES-1:0] n_lane;
    logic                  cull;
    logic                  cx;
    logic                  cz;
    t_edge                 cl;
    t_edge                 cb;
    t_edge                 cr;
    t_edge                 ct;
    t_diff                 nx;
    t_diff                 dx;
    t_diff                 nz;
    t_diff                 dz;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_lane  = r_lane;

    always_comb begin
        cl     = ext_e(i_cfg.clip_left);
        cb     = ext_e(i_cfg.clip_bottom);
        cr     = ext_e(i_cfg.clip_right);
        ct     = ext_e(i_cfg.clip_top);
        n_item = i_item;
        if (PHASE == 0) begin
            cull = (i_item.l > cr) || (i_item.r < cl) || (i_item.b > ct) || (i_item.t < cb);
            cx   = i_item.l < cl;
            nx   = ext_d(cl) - ext_d(i_item.l);
            dx   = ext_d(i_item.r) - ext_d(i_item.l);
            cz   = i_item.b < cb;
            nz   = ext_d(cb) - ext_d(i_item.b);
            dz   = ext_d(i_item.t) - ext_d(i_item.b);
            if (cx) begin
                n_item.l = cl;
            end
            if (cz) begin
                n_item.b = cb;
            end
            n_lane[0] = '{en: cx, a: i_item.u[0], f: i_item.u[1], n: nx, d: dx};
            n_lane[1] = '{en: cx, a: i_item.u[3], f: i_item.u[2], n: nx, d: dx};
            n_lane[2] = '{en: cz, a: i_item.v[0], f: i_item.v[3], n: nz, d: dz};
            n_lane[3] = '{en: cz, a: i_item.v[1], f: i_item.v[2], n: nz, d: dz};
        end else begin
            cull = 1'b0;
            cx   = i_item.r > cr;
            nx   = ext_d(i_item.r) - ext_d(cr);
            dx   = ext_d(i_item.r) - ext_d(i_item.l);
            cz   = i_item.t > ct;
            nz   = ext_d(i_item.t) - ext_d(ct);
            dz   = ext_d(i_item.t) - ext_d(i_item.b);
            if (cx) begin
                n_item.r = cr;
            end
            if (cz) begin
                n_item.t = ct;
            end
            n_lane[0] = '{en: cx, a: i_item.u[2], f: i_item.u[3], n: nx, d: dx};
            n_lane[1] = '{en: cx, a: i_item.u[1], f: i_item.u[0], n: nx, d: dx};
            n_lane[2] = '{en: cz, a: i_item.v[2], f: i_item.v[1], n: nz, d: dz};
            n_lane[3] = '{en: cz, a: i_item.v[3], f: i_item.v[0], n: nz, d: dz};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && !cull;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
            r_lane <= n_lane;
        end
    end

endmodule

/* rtl/tqrc_clamp.sv */
// Four-lane UV interpolation pipeline: multiply, sum, then one quotient bit per stage.
module tqrc_clamp import tqrc_pkg::*; (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  t_quad                               i_item,
    input  t_lane [NUM_LANES-1:0]               i_lane,
    output logic                                o_valid,
    input  logic                                i_ready,
    output t_quad                               o_item,
    output logic [NUM_LANES-1:0][UV_WIDTH-1:0]  o_res
);

    localparam int S = UV_WIDTH + 2;

    logic [S-1:0] r_valid;
    logic [S:0]   en;
    t_quad        r_item [S];
    t_mlane       r_mul  [NUM_LANES];
    t_mlane       n_mul  [NUM_LANES];
    t_dlane       r_div  [UV_WIDTH+1][NUM_LANES];
    t_dlane       n_sum  [NUM_LANES];
    t_dlane       n_step [UV_WIDTH][NUM_LANES];

    assign en[S] = i_ready;
    for (genvar s = 0; s < S; s++) begin : g_en
        assign en[s] = !r_valid[s] || en[s+1];
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[S-1];
    assign o_item  = r_item[S-1];

    always_comb begin
        logic signed [DW-1:0] sn;
        logic signed [DW-1:0] sd;
        logic [DW-1:0]        dn;
        for (int l = 0; l < NUM_LANES; l++) begin
            sn = i_lane[l].n;
            sd = i_lane[l].d;
            dn = sd - sn;
            n_mul[l].pf = i_lane[l].en && (sd[DW-1] || (sd == '0) || (sn >= sd));
            n_mul[l].pa = !i_lane[l].en || (!n_mul[l].pf && (sn[DW-1] || (sn == '0)));
            n_mul[l].a  = i_lane[l].a;
            n_mul[l].f  = i_lane[l].f;
            n_mul[l].d  = sd[DU-1:0];
            n_mul[l].p1 = NW'(i_lane[l].a) * NW'(dn[DU-1:0]);
            n_mul[l].p2 = NW'(i_lane[l].f) * NW'(sn[DU-1:0]);
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_sum[l].pa  = r_mul[l].pa;
            n_sum[l].pf  = r_mul[l].pf;
            n_sum[l].a   = r_mul[l].a;
            n_sum[l].f   = r_mul[l].f;
            n_sum[l].d   = r_mul[l].d;
            n_sum[l].rem = r_mul[l].p1 + r_mul[l].p2 + NW'(r_mul[l].d >> 1);
            n_sum[l].q   = '0;
        end
    end

    always_comb begin
        logic [NW-1:0] dsh;
        for (int k = 0; k < UV_WIDTH; k++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                n_step[k][l] = r_div[k][l];
                dsh = NW'(r_div[k][l].d) << (UV_WIDTH - 1 - k);
                if (r_div[k][l].rem >= dsh) begin
                    n_step[k][l].rem = r_div[k][l].rem - dsh;
                    n_step[k][l].q[UV_WIDTH-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_div[UV_WIDTH][l].pf) begin
                o_res[l] = r_div[UV_WIDTH][l].f;
            end else if (r_div[UV_WIDTH][l].pa) begin
                o_res[l] = r_div[UV_WIDTH][l].a;
            end else begin
                o_res[l] = r_div[UV_WIDTH][l].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < S; s++) begin
                if (en[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item[0] <= i_item;
            r_mul     <= n_mul;
        end
        if (en[1]) begin
            r_div[0] <= n_sum;
        end
        for (int s = 1; s < S; s++) begin
            if (en[s]) begin
                r_item[s] <= r_item[s-1];
            end
        end
        for (int k = 0; k < UV_WIDTH; k++) begin
            if (en[k+2]) begin
                r_div[k+1] <= n_step[k];
            end
        end
    end

endmodule

/* rtl/textured_quad_rect_clipper.sv */
// Top level of the textured quad rectangle clipper: config registers, pipeline chain, output.
// Streams one glyph quad per clock when the output is taken every cycle. Each input
// transaction passes through translate, left/bottom setup, a UV_WIDTH+2 stage
// interpolation pipe, right/top setup, a second interpolation pipe, and the output
// register. Each interpolation pipe is a restoring divider that resolves one
// quotient bit per stage in four lanes. Culled quads are accepted and produce no result.
// Config writes are always accepted; unknown indexes are ignored.
module textured_quad_rect_clipper import tqrc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_in                      i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_out                     o_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  t_pos                     i_cfg_data
);

    t_cfg                           r_cfg;
    logic                           x_valid;
    logic                           x_ready;
    t_quad                          x_item;
    logic                           sa_valid;
    logic                           sa_ready;
    t_quad                          sa_item;
    t_lane [NUM_LANES-1:0]          sa_lane;
    logic                           ca_valid;
    logic                           ca_ready;
    t_quad                          ca_item;
    logic [NUM_LANES-1:0][UV_WIDTH-1:0] ca_res;
    t_quad                          qa;
    logic                           sb_valid;
    logic                           sb_ready;
    t_quad                          sb_item;
    t_lane [NUM_LANES-1:0]          sb_lane;
    logic                           cb_valid;
    logic                           cb_ready;
    t_quad                          cb_item;
    logic [NUM_LANES-1:0][UV_WIDTH-1:0] cb_res;
    t_quad                          qb;
    logic                           r_valid;
    t_out                           r_out;
    t_out                           n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X:    r_cfg.offset_x    <= i_cfg_data;
                CFG_OFFSET_Z:    r_cfg.offset_z    <= i_cfg_data;
                CFG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data;
                CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data;
                CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data;
                CFG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tqrc_xlate u_xlate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_valid (x_valid),
        .i_ready (x_ready),
        .o_item  (x_item)
    );

    tqrc_setup #(.PHASE(0)) u_setup_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_ready (x_ready),
        .i_item  (x_item),
        .i_cfg   (r_cfg),
        .o_valid (sa_valid),
        .i_ready (sa_ready),
        .o_item  (sa_item),
        .o_lane  (sa_lane)
    );

    tqrc_clamp u_clamp_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sa_valid),
        .o_ready (sa_ready),
        .i_item  (sa_item),
        .i_lane  (sa_lane),
        .o_valid (ca_valid),
        .i_ready (ca_ready),
        .o_item  (ca_item),
        .o_res   (ca_res)
    );

    always_comb begin
        qa      = ca_item;
        qa.u[0] = ca_res[0];
        qa.u[3] = ca_res[1];
        qa.v[0] = ca_res[2];
        qa.v[1] = ca_res[3];
    end

    tqrc_setup #(.PHASE(1)) u_setup_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ca_valid),
        .o_ready (ca_ready),
        .i_item  (qa),
        .i_cfg   (r_cfg),
        .o_valid (sb_valid),
        .i_ready (sb_ready),
        .o_item  (sb_item),
        .o_lane  (sb_lane)
    );

    tqrc_clamp u_clamp_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sb_valid),
        .o_ready (sb_ready),
        .i_item  (sb_item),
        .i_lane  (sb_lane),
        .o_valid (cb_valid),
        .i_ready (cb_ready),
        .o_item  (cb_item),
        .o_res   (cb_res)
    );

    always_comb begin
        qb      = cb_item;
        qb.u[2] = cb_res[0];
        qb.u[1] = cb_res[1];
        qb.v[2] = cb_res[2];
        qb.v[3] = cb_res[3];
    end

    always_comb begin
        n_out.out_left_x   = sat_pos(qb.l);
        n_out.out_bottom_z = sat_pos(qb.b);
        n_out.out_right_x  = sat_pos(qb.r);
        n_out.out_top_z    = sat_pos(qb.t);
        n_out.out_u0       = qb.u[0];
        n_out.out_v0       = qb.v[0];
        n_out.out_u1       = qb.u[1];
        n_out.out_v1       = qb.v[1];
        n_out.out_u2       = qb.u[2];
        n_out.out_v2       = qb.v[2];
        n_out.out_u3       = qb.u[3];
        n_out.out_v3       = qb.v[3];
    end

    assign cb_ready = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (cb_ready) begin
            r_valid <= cb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cb_ready) begin
            r_out <= n_out;
        end
    end

    // surviving quads always end inside the clip rectangle
    a_inside_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_left_x >= r_cfg.clip_left) &&
                    (o_data.out_right_x <= r_cfg.clip_right) &&
                    (o_data.out_bottom_z >= r_cfg.clip_bottom) &&
                    (o_data.out_top_z <= r_cfg.clip_top))
        else $error("result outside clip rectangle");

    // input backpressure only when the whole pipe is full up to the output
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled with room in pipeline");

endmodule

/* test/tb_top.sv */
// Testbench for textured_quad_rect_clipper: directed table, then random quads against a predictor.
module tb_top;
    import tqrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RAND_PER_PHASE = 300;
    localparam int NUM_PHASES     = 6;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    t_in                      i_data = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    t_out                     o_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = '0;
    t_pos                     i_cfg_data = '0;

    textured_quad_rect_clipper dut (.*);

    always #2 i_clk = ~i_clk;

    typedef struct {
        t_in  quad;
        bit   typed;
        bit   kept;
        t_out res;
    } t_row;

    longint shadow_cfg [6];
    t_out   expected_quads [$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;
    bit     hold_req = 1'b0;
    bit     pending_typed = 1'b0;
    bit     pending_kept;
    t_out   pending_res;

    function automatic longint lerp_uv(longint a, longint f, longint n, longint d);
        if (d <= 0 || n >= d) return f;
        if (n <= 0) return a;
        return (a * (d - n) + f * n + d / 2) / d;
    endfunction

    function automatic t_pos clamp_pos(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_pos'(v);
    endfunction

    function automatic bit clip_quad(input t_in q, output t_out y);
        longint l, b, r, t, n, d;
        longint u [4];
        longint v [4];
        l = longint'(q.left_x) + shadow_cfg[CFG_OFFSET_X];
        b = longint'(q.bottom_z) + shadow_cfg[CFG_OFFSET_Z];
        r = longint'(q.right_x) + shadow_cfg[CFG_OFFSET_X];
        t = longint'(q.top_z) + shadow_cfg[CFG_OFFSET_Z];
        u[0] = q.tex_u0; v[0] = q.tex_v0; u[1] = q.tex_u1; v[1] = q.tex_v1;
        u[2] = q.tex_u2; v[2] = q.tex_v2; u[3] = q.tex_u3; v[3] = q.tex_v3;
        y = '0;
        if (l > shadow_cfg[CFG_CLIP_RIGHT] || r < shadow_cfg[CFG_CLIP_LEFT] ||
            b > shadow_cfg[CFG_CLIP_TOP] || t < shadow_cfg[CFG_CLIP_BOTTOM]) return 1'b0;
        if (l < shadow_cfg[CFG_CLIP_LEFT]) begin
            n = shadow_cfg[CFG_CLIP_LEFT] - l; d = r - l;
            l = shadow_cfg[CFG_CLIP_LEFT];
            u[0] = lerp_uv(u[0], u[1], n, d);
            u[3] = lerp_uv(u[3], u[2], n, d);
        end
        if (b < shadow_cfg[CFG_CLIP_BOTTOM]) begin
            n = shadow_cfg[CFG_CLIP_BOTTOM] - b; d = t - b;
            b = shadow_cfg[CFG_CLIP_BOTTOM];
            v[0] = lerp_uv(v[0], v[3], n, d);
            v[1] = lerp_uv(v[1], v[2], n, d);
        end
        if (r > shadow_cfg[CFG_CLIP_RIGHT]) begin
            n = r - shadow_cfg[CFG_CLIP_RIGHT]; d = r - l;
            r = shadow_cfg[CFG_CLIP_RIGHT];
            u[2] = lerp_uv(u[2], u[3], n, d);
            u[1] = lerp_uv(u[1], u[0], n, d);
        end
        if (t > shadow_cfg[CFG_CLIP_TOP]) begin
            n = t - shadow_cfg[CFG_CLIP_TOP]; d = t - b;
            t = shadow_cfg[CFG_CLIP_TOP];
            v[2] = lerp_uv(v[2], v[1], n, d);
            v[3] = lerp_uv(v[3], v[0], n, d);
        end
        y.out_left_x = clamp_pos(l);
        y.out_bottom_z = clamp_pos(b);
        y.out_right_x = clamp_pos(r);
        y.out_top_z = clamp_pos(t);
        y.out_u0 = t_uv'(u[0]); y.out_v0 = t_uv'(v[0]);
        y.out_u1 = t_uv'(u[1]); y.out_v1 = t_uv'(v[1]);
        y.out_u2 = t_uv'(u[2]); y.out_v2 = t_uv'(v[2]);
        y.out_u3 = t_uv'(u[3]); y.out_v3 = t_uv'(v[3]);
        return 1'b1;
    endfunction

    // input transactions, config transactions, result check
    always @(posedge i_clk) begin
        t_out y;
        bit   kept;
        if (i_rst_n && i_valid && o_ready) begin
            if (pending_typed) begin
                if (pending_kept) expected_quads.push_back(pending_res);
            end else begin
                kept = clip_quad(i_data, y);
                if (kept) expected_quads.push_back(y);
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready && i_cfg_index < 6)
            shadow_cfg[i_cfg_index] = longint'(i_cfg_data);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_data);
            end else begin
                y = expected_quads.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (y[16*k +: 16] !== o_data[16*k +: 16]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d (from last): expected %h actual %h",
                                     k, y[16*k +: 16], o_data[16*k +: 16]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
        end
    end

    task automatic send_quad(input t_in q, input bit typed = 1'b0, input bit kept = 1'b0,
                             input t_out res = '0);
        @(negedge i_clk);
        pending_typed = typed;
        pending_kept = kept;
        pending_res = res;
        while (!calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= q;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input t_pos val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_quads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_uv rnd_uv();
        return t_uv'($urandom);
    endfunction

    function automatic t_in random_quad();
        t_in    q;
        longint lo_x, hi_x, lo_z, hi_z, a, c;
        q = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 20) return q;
        lo_x = shadow_cfg[CFG_CLIP_LEFT]; hi_x = shadow_cfg[CFG_CLIP_RIGHT];
        lo_z = shadow_cfg[CFG_CLIP_BOTTOM]; hi_z = shadow_cfg[CFG_CLIP_TOP];
        if (lo_x > hi_x) begin a = lo_x; lo_x = hi_x; hi_x = a; end
        if (lo_z > hi_z) begin a = lo_z; lo_z = hi_z; hi_z = a; end
        a = lo_x - longint'($urandom_range(800)) + longint'($urandom_range(800));
        c = hi_x - longint'($urandom_range(800)) + longint'($urandom_range(800));
        if (a > c && $urandom_range(3) != 0) begin lo_x = a; a = c; c = lo_x; end
        q.left_x = t_pos'(a - shadow_cfg[CFG_OFFSET_X]);
        q.right_x = t_pos'(c - shadow_cfg[CFG_OFFSET_X]);
        a = lo_z - longint'($urandom_range(800)) + longint'($urandom_range(800));
        c = hi_z - longint'($urandom_range(800)) + longint'($urandom_range(800));
        if (a > c && $urandom_range(3) != 0) begin lo_z = a; a = c; c = lo_z; end
        q.bottom_z = t_pos'(a - shadow_cfg[CFG_OFFSET_Z]);
        q.top_z = t_pos'(c - shadow_cfg[CFG_OFFSET_Z]);
        return q;
    endfunction

    function automatic t_in mk(int l, int b, int r, int t, int ua, int ub);
        t_in q;
        q.left_x = t_pos'(l); q.bottom_z = t_pos'(b);
        q.right_x = t_pos'(r); q.top_z = t_pos'(t);
        q.tex_u0 = t_uv'(ua); q.tex_v0 = t_uv'(ua); q.tex_u1 = t_uv'(ub);
        q.tex_v1 = t_uv'(ua); q.tex_u2 = t_uv'(ub); q.tex_v2 = t_uv'(ub);
        q.tex_u3 = t_uv'(ua); q.tex_v3 = t_uv'(ub);
        return q;
    endfunction

    function automatic t_out pass_through(t_in q);
        return t_out'(q);
    endfunction

    initial begin
        t_row   rows [$];
        t_row   row;
        int     phase_cfg [NUM_PHASES][6] = '{
            '{0, 0, -800, -800, 800, 800},
            '{100, -200, -32768, -32768, 32767, 32767},
            '{32767, -32768, -2000, -1000, 3000, 500},
            '{-500, 300, 1000, -1000, -1000, 1000},
            '{-100, -100, -3000, 500, 3000, -500},
            '{0, 0, 0, 0, 0, 0}
        };
        for (int k = 0; k < 6; k++) shadow_cfg[k] = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // at reset the clip window is the single point at the origin
        row.quad = '0; row.typed = 1'b1; row.kept = 1'b1; row.res = '0;
        rows.push_back(row);
        row.quad = mk(16, 0, 32, 0, 1, 2); row.kept = 1'b0; rows.push_back(row);
        foreach (rows[i]) begin
            send_quad(rows[i].quad, rows[i].typed, rows[i].kept, rows[i].res);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1)
                for (int k = 0; k < 6; k++) phase_cfg[p][k] = $urandom_range(8000) - 4000;
            for (int k = 0; k < 6; k++)
                write_reg(CFG_IDX_WIDTH'(k), t_pos'(phase_cfg[p][k]));
            write_reg(CFG_IDX_WIDTH'(6 + (p % 2)), t_pos'($urandom));
            calm = (p == 1);
            if (p == 2) hold_req = 1'b1;
            if (p == 0) begin
                rows.delete();
                row.typed = 1'b1;
                row.kept = 1'b0;
                row.quad = mk(801, -10, 900, 10, 0, 65535); rows.push_back(row);
                row.quad = mk(-900, -10, -801, 10, 0, 65535); rows.push_back(row);
                row.quad = mk(-10, 801, 10, 900, 0, 65535); rows.push_back(row);
                row.quad = mk(-10, -900, 10, -801, 0, 65535); rows.push_back(row);
                row.kept = 1'b1;
                row.quad = mk(0, 0, 100, 100, 0, 65535);
                row.res = pass_through(row.quad); rows.push_back(row);
                row.quad = mk(-800, -800, 800, 800, 65535, 0);
                row.res = pass_through(row.quad); rows.push_back(row);
                row.typed = 1'b0;
                row.quad = mk(-1600, 0, 0, 100, 0, 65535); rows.push_back(row);
                row.quad = mk(0, -1600, 100, 0, 65535, 0); rows.push_back(row);
                row.quad = mk(0, 0, 1600, 100, 0, 65535); rows.push_back(row);
                row.quad = mk(0, 0, 100, 1600, 65535, 0); rows.push_back(row);
                row.quad = mk(-1000, -1000, 1000, 1000, 12345, 54321); rows.push_back(row);
                row.quad = mk(-32768, -32768, 32767, 32767, 0, 65535); rows.push_back(row);
                row.quad = mk(-32768, -32768, 32767, 32767, 65535, 65535); rows.push_back(row);
                row.quad = mk(-801, -801, -799, -799, 1, 65534); rows.push_back(row);
                row.quad = mk(800, 800, 800, 800, 7, 9); rows.push_back(row);
                row.quad = mk(500, -900, -500, 900, 0, 65535); rows.push_back(row);
                foreach (rows[i]) begin
                    send_quad(rows[i].quad, rows[i].typed, rows[i].kept, rows[i].res);
                end
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) send_quad(random_quad());
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
